// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

    // Byte width of keys, data and permutation entries.
    localparam int BYTE_W = 8;

    // Size of the permutation and of the key store.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // The key byte count must be able to hold TABLE_DEPTH itself.
    localparam int CNT_W = IDX_W + 1;

    // Default for the longest key that is stored.
    localparam int KEY_MAX_DEF = 256;

endpackage

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
    parameter int WIDTH = rc4_pkg::BYTE_W,
    parameter int DEPTH = rc4_pkg::TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    import rc4_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// A data byte is taken in IDLE, then PR_RJ to PR_OUT register its result on o_data_out once the
// output is free; no new byte is taken before then, as the step needs three dependent
// reads and two swap writes that share the one read and one write port of the permutation RAM.
// Key bytes are stored in IDLE; the last one adds a fill pass and a key schedule step per entry.
// Reset is synchronous, active low: after it, a pass writes the identity permutation
// into the RAM while the input is stalled, then the block starts with empty key and zero indices.
module rc4_stream_cipher #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [rc4_pkg::BYTE_W-1:0] i_byte_in,
    input  logic                       i_last_key,
    // Output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rc4_pkg::BYTE_W-1:0] o_data_out
);
    import rc4_pkg::*;

    localparam logic [CNT_W-1:0] KeyMax  = CNT_W'(KEY_MAX);
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_DEPTH - 1);

    // One-hot sequencer. FILL writes the identity permutation, the KS_* states together
    // run one key schedule step, the PR_* states one generator step for a data byte.
    typedef enum logic [10:0] {
        ST_FILL   = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_KS_RD  = 11'b000_0000_0100,
        ST_KS_ADD = 11'b000_0000_1000,
        ST_KS_WN  = 11'b000_0001_0000,
        ST_KS_WJ  = 11'b000_0010_0000,
        ST_PR_RJ  = 11'b000_0100_0000,
        ST_PR_WI  = 11'b000_1000_0000,
        ST_PR_WJ  = 11'b001_0000_0000,
        ST_PR_RT  = 11'b010_0000_0000,
        ST_PR_OUT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]  r_i;          // generator index i
    logic [IDX_W-1:0]  r_j;          // generator index j, also the schedule's j
    logic [CNT_W-1:0]  r_key_count;  // key bytes stored so far
    logic [IDX_W-1:0]  r_n;          // sweep index for the fill and the schedule
    logic [IDX_W-1:0]  r_k;          // key position, n modulo the key length
    logic              r_sched;      // the running fill is followed by a schedule
    logic [BYTE_W-1:0] r_si;         // first entry read in a step
    logic [BYTE_W-1:0] r_sj;         // second entry read in a step
    logic [BYTE_W-1:0] r_byte;       // data byte that waits for its keystream byte
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_data_out;

    logic              in_xfer;
    logic              out_free;
    logic              key_store_en;
    logic [CNT_W-1:0]  key_len;
    logic [CNT_W-1:0]  k_plus;
    logic [IDX_W-1:0]  i_next;
    logic [IDX_W-1:0]  ks_sum;
    logic [IDX_W-1:0]  pr_j_next;

    // Permutation RAM ports.
    logic              s_wr_en;
    logic [IDX_W-1:0]  s_wr_addr;
    logic [BYTE_W-1:0] s_wr_data;
    logic              s_rd_en;
    logic [IDX_W-1:0]  s_rd_addr;
    logic [BYTE_W-1:0] s_rd_data;

    // Key RAM read data.
    logic [BYTE_W-1:0] k_rd_data;

    // The input is taken only in IDLE; every other state is busy for a
    // number of cycles that does not depend on the output side, except the
    // last step of a data byte, which waits for a free output register.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Key bytes beyond KEY_MAX are dropped, but a last-key flag on them still
    // starts the schedule.
    assign key_store_en = in_xfer && !i_mode && (r_key_count < KeyMax);

    // An empty key behaves as a one-byte key.
    assign key_len = (r_key_count == '0) ? CNT_W'(1) : r_key_count;
    assign k_plus  = {1'b0, r_k} + CNT_W'(1);

    assign i_next    = r_i + IDX_W'(1);
    assign ks_sum    = r_j + s_rd_data + k_rd_data;
    assign pr_j_next = r_j + s_rd_data;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_store_en),
        .i_wr_addr (r_key_count[IDX_W-1:0]),
        .i_wr_data (i_byte_in),
        .i_rd_en   (r_state == ST_KS_RD),
        .i_rd_addr (r_k),
        .o_rd_data (k_rd_data)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_perm_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    // The single RAM port pair is shared by every step; the sequencer picks
    // the address and data for the cycle it is in.
    always_comb begin
        s_wr_en   = 1'b0;
        s_wr_addr = r_n;
        s_wr_data = r_n;
        s_rd_en   = 1'b0;
        s_rd_addr = r_n;
        case (r_state)
            ST_FILL: begin
                s_wr_en = 1'b1;
            end
            ST_IDLE: begin
                // A data byte reads S[i+1] in the cycle it is taken.
                s_rd_en   = in_xfer && i_mode;
                s_rd_addr = i_next;
            end
            ST_KS_RD: begin
                s_rd_en = 1'b1;
            end
            ST_KS_ADD: begin
                s_rd_en   = 1'b1;
                s_rd_addr = ks_sum;
            end
            ST_KS_WN: begin
                // S[n] takes the old S[j].
                s_wr_en   = 1'b1;
                s_wr_data = s_rd_data;
            end
            ST_KS_WJ: begin
                // S[j] takes the old S[n]; when j equals n this rewrites the
                // same value, which is what the swap gives.
                s_wr_en   = 1'b1;
                s_wr_addr = r_j;
                s_wr_data = r_si;
            end
            ST_PR_RJ: begin
                s_rd_en   = 1'b1;
                s_rd_addr = pr_j_next;
            end
            ST_PR_WI: begin
                s_wr_en   = 1'b1;
                s_wr_addr = r_i;
                s_wr_data = s_rd_data;
            end
            ST_PR_WJ: begin
                s_wr_en   = 1'b1;
                s_wr_addr = r_j;
                s_wr_data = r_si;
            end
            ST_PR_RT: begin
                // After the swap S[i] + S[j] is the same sum of the two
                // entries read before it.
                s_rd_en   = 1'b1;
                s_rd_addr = r_si + r_sj;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (r_n == LastIdx) begin
                    n_state = r_sched ? ST_KS_RD : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_mode) begin
                        n_state = ST_PR_RJ;
                    end else if (i_last_key) begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_KS_RD:  n_state = ST_KS_ADD;
            ST_KS_ADD: n_state = ST_KS_WN;
            ST_KS_WN:  n_state = ST_KS_WJ;
            ST_KS_WJ: begin
                n_state = (r_n == LastIdx) ? ST_IDLE : ST_KS_RD;
            end
            ST_PR_RJ:  n_state = ST_PR_WI;
            ST_PR_WI:  n_state = ST_PR_WJ;
            ST_PR_WJ:  n_state = ST_PR_RT;
            ST_PR_RT:  n_state = ST_PR_OUT;
            ST_PR_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_FILL;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_n         <= '0;
            r_k         <= '0;
            r_sched     <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (key_store_en) begin
                r_key_count <= r_key_count + CNT_W'(1);
            end

            case (r_state)
                ST_FILL: begin
                    r_n <= r_n + IDX_W'(1);
                end
                ST_IDLE: begin
                    if (in_xfer && i_mode) begin
                        r_i <= i_next;
                    end else if (in_xfer && i_last_key) begin
                        r_n     <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_sched <= 1'b1;
                    end
                end
                ST_KS_ADD: begin
                    r_j <= ks_sum;
                end
                ST_KS_WJ: begin
                    r_n <= r_n + IDX_W'(1);
                    r_k <= (k_plus == key_len) ? '0 : r_k + IDX_W'(1);
                    if (r_n == LastIdx) begin
                        // Schedule done: fresh generator, and the next key
                        // byte starts a new key.
                        r_i         <= '0;
                        r_j         <= '0;
                        r_key_count <= '0;
                        r_sched     <= 1'b0;
                    end
                end
                ST_PR_RJ: begin
                    r_j <= pr_j_next;
                end
                default: begin
                end
            endcase

            if (r_state == ST_PR_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_mode) begin
            r_byte <= i_byte_in;
        end
        if (r_state == ST_KS_ADD || r_state == ST_PR_RJ) begin
            r_si <= s_rd_data;
        end
        if (r_state == ST_PR_WI) begin
            r_sj <= s_rd_data;
        end
        if (r_state == ST_PR_OUT && out_free) begin
            r_data_out <= r_byte ^ s_rd_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;

    // A result appears only from the last step of a data byte.
    a_out_from_pr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_PR_OUT)
        else $error("output valid rose outside the output step");

    // The key position stays inside the stored key during the schedule.
    a_key_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_RD) |-> ({1'b0, r_k} < key_len))
        else $error("key position beyond key length");

    // Finishing the schedule leaves both indices and the key count cleared.
    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_WJ && r_n == LastIdx) |=>
            (r_i == '0 && r_j == '0 && r_key_count == '0 && r_state == ST_IDLE))
        else $error("schedule end left stale state");

    // A data transfer on the input always starts a generator step.
    a_xfer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_mode) |=> r_state == ST_PR_RJ)
        else $error("data transfer did not start a generator step");

endmodule
